// ===== sv/rmle_pkg.sv =====
package rmle_pkg;

	localparam int LEVEL_W = 7;
	localparam int THR_W   = 8;
	localparam int ERR_W   = 9;

	localparam logic [LEVEL_W-1:0] SAMPLE_MAX = 7'd100;
	localparam logic [THR_W-1:0]   THR_RESET  = 8'd30;

endpackage

// ===== sv/rmle_cell.sv =====
// One slot of the sorted window. Each beat the oldest entry leaves the row,
// the entries above it slide down one slot, and the new sample drops in at
// its sorted place; a cell reads only x, below_oldest and its two neighbors.
module rmle_cell #(
	parameter int          AW      = 3,
	parameter bit          FIRST   = 1'b0,
	parameter bit          LAST    = 1'b0,
	parameter logic [AW-1:0] AGE_RST = '0,
	parameter logic [AW-1:0] AGE_MAX = '0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  logic [rmle_pkg::LEVEL_W-1:0] x,
	input  logic                         below_oldest,
	input  logic [rmle_pkg::LEVEL_W-1:0] next_level,
	input  logic [AW-1:0]                next_age,
	input  logic [rmle_pkg::LEVEL_W-1:0] prev_r_level,
	input  logic [AW-1:0]                prev_r_age,
	output logic [rmle_pkg::LEVEL_W-1:0] level,
	output logic [AW-1:0]                age,
	output logic                         oldest,
	output logic [rmle_pkg::LEVEL_W-1:0] r_level,
	output logic [AW-1:0]                r_age,
	output logic [rmle_pkg::LEVEL_W-1:0] n_level
);

	logic [rmle_pkg::LEVEL_W-1:0] level_q;
	logic [AW-1:0]                age_q;
	logic [AW-1:0]                n_age;
	logic                         r_below;
	logic                         lo_ok;

	assign oldest = (age_q == AGE_MAX);

	// contents of this slot once the oldest entry is taken out
	always_comb begin
		if (below_oldest || oldest) begin
			r_level = next_level;
			r_age   = next_age;
		end else begin
			r_level = level_q;
			r_age   = age_q;
		end
	end

	// the top slot has nothing left after removal
	assign r_below = LAST ? 1'b0 : (r_level < x);
	assign lo_ok   = FIRST ? 1'b1 : (prev_r_level < x);

	always_comb begin
		if (r_below) begin
			n_level = r_level;
			n_age   = r_age + AW'(1);
		end else if (lo_ok) begin
			n_level = x;
			n_age   = '0;
		end else begin
			n_level = prev_r_level;
			n_age   = prev_r_age + AW'(1);
		end
	end

	// zero values keep the row sorted from reset; ages start as a permutation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			age_q   <= AGE_RST;
		end else if (load) begin
			level_q <= n_level;
			age_q   <= n_age;
		end
	end

	assign level = level_q;
	assign age   = age_q;

endmodule

// ===== sv/running_median_line_error.sv =====
// Running median of reflected-light samples, reported as an error against a
// signed line threshold. One sample is taken per beat on s_axis and gives one
// registered result on m_axis; with m_axis_tready held high a new sample
// is taken every cycle, the figure being set by the row of WINDOW sorted
// cells, which drop the oldest sample and insert the new one on each
// accepted beat. Samples above 100 saturate to 100. For the first WINDOW
// samples after reset, or after a threshold write, the saturated sample is
// passed through and m_axis_tuser is high; after that filtered_level is entry
// WINDOW/2 of the sorted window (upper median for an even window). Threshold
// writes go in on the cfg channel, which is always ready, and must only come
// while the block is idle. No clearing pass is needed after reset.
module running_median_line_error #(
	parameter int WINDOW = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	// threshold write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,      // [7:0] line_threshold (signed)
	// sample input
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [6:0] light_sample, [7] zero
	// result output
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [8:0] line_error, [15:9] filtered_level
	output logic        m_axis_tuser   // [0] warming_up
);

	localparam int LW  = rmle_pkg::LEVEL_W;
	localparam int AW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int FW  = $clog2(WINDOW + 1);
	localparam int MID = WINDOW / 2;

	logic [rmle_pkg::THR_W-1:0] thr_q;
	logic [FW-1:0]              fill_q;
	logic                       out_valid_q;
	logic [rmle_pkg::ERR_W-1:0] err_q;
	logic [LW-1:0]              filt_q;
	logic                       warm_q;

	logic          accept;
	logic          warm;
	logic [LW-1:0] raw;
	logic [LW-1:0] sample;
	logic [LW-1:0] level_sel;

	// per-cell wiring of the sorted row
	logic [LW-1:0]     c_level [WINDOW];
	logic [AW-1:0]     c_age   [WINDOW];
	logic [LW-1:0]     c_r_lvl [WINDOW];
	logic [AW-1:0]     c_r_age [WINDOW];
	logic [LW-1:0]     c_n_lvl [WINDOW];
	logic [WINDOW-1:0] oldest_vec;
	logic [WINDOW-1:0] below_vec;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign raw    = s_axis_tdata[LW-1:0];
	assign sample = (raw > rmle_pkg::SAMPLE_MAX) ? rmle_pkg::SAMPLE_MAX : raw;
	assign warm   = (fill_q < FW'(WINDOW));

	genvar gi;
	generate
		for (gi = 0; gi < WINDOW; gi++) begin : g_cell
			// oldest entry sits somewhere below this slot
			if (gi == 0) begin : g_b0
				assign below_vec[gi] = 1'b0;
			end else begin : g_bn
				assign below_vec[gi] = |oldest_vec[gi-1:0];
			end

			logic [LW-1:0] nb_level;
			logic [AW-1:0] nb_age;
			logic [LW-1:0] pr_level;
			logic [AW-1:0] pr_age;

			if (gi == WINDOW - 1) begin : g_top
				assign nb_level = c_level[gi];
				assign nb_age   = c_age[gi];
			end else begin : g_mid
				assign nb_level = c_level[gi+1];
				assign nb_age   = c_age[gi+1];
			end

			if (gi == 0) begin : g_bot
				assign pr_level = c_r_lvl[gi];
				assign pr_age   = c_r_age[gi];
			end else begin : g_up
				assign pr_level = c_r_lvl[gi-1];
				assign pr_age   = c_r_age[gi-1];
			end

			rmle_cell #(
				.AW      (AW),
				.FIRST   (gi == 0),
				.LAST    (gi == WINDOW - 1),
				.AGE_RST (AW'(gi)),
				.AGE_MAX (AW'(WINDOW - 1))
			) u_cell (
				.clk          (clk),
				.arst_n       (arst_n),
				.load         (accept),
				.x            (sample),
				.below_oldest (below_vec[gi]),
				.next_level   (nb_level),
				.next_age     (nb_age),
				.prev_r_level (pr_level),
				.prev_r_age   (pr_age),
				.level        (c_level[gi]),
				.age          (c_age[gi]),
				.oldest       (oldest_vec[gi]),
				.r_level      (c_r_lvl[gi]),
				.r_age        (c_r_age[gi]),
				.n_level      (c_n_lvl[gi])
			);
		end
	endgenerate

	// median is read from the row as it will be after this sample
	assign level_sel = warm ? sample : c_n_lvl[MID];

	// threshold and warm-up count; a threshold write restarts the fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= rmle_pkg::THR_RESET;
			fill_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			thr_q  <= cfg_data;
			fill_q <= '0;
		end else if (accept && warm) begin
			fill_q <= fill_q + FW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			err_q  <= {2'b00, level_sel} - {thr_q[rmle_pkg::THR_W-1], thr_q};
			filt_q <= level_sel;
			warm_q <= warm;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {filt_q, err_q};
	assign m_axis_tuser  = warm_q;

`ifndef NO_ASSERTIONS
	// ages stay a permutation, so exactly one entry is due to leave
	a_one_oldest: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(oldest_vec))
		else $error("sorted row does not hold exactly one oldest entry");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[15:9] <= rmle_pkg::SAMPLE_MAX))
		else $error("filtered level above saturation limit");

	a_err_match: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[8:0] ==
			({2'b00, m_axis_tdata[15:9]} - {thr_q[rmle_pkg::THR_W-1], thr_q})))
		else $error("line error does not match level and threshold");

	a_warm_done: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !(cfg_valid && cfg_ready) && fill_q == FW'(WINDOW)) |=> !m_axis_tuser)
		else $error("warm-up flag set after window filled");
`endif

endmodule
